### design/tsa_pkg.sv
// Shared types and constants for the two-class time-share arbiter.
`default_nettype none

package tsa_pkg;

    localparam int unsigned FIELD_TIME_W = 48;
    localparam int unsigned PCT_W        = 7;
    localparam int unsigned CFG_IDX_W    = 1;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_DECIDE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_START = 2'd1;
    localparam logic [1:0] STATUS_SQ_FULL  = 2'd2;
    localparam logic [1:0] STATUS_EVICT    = 2'd3;

    localparam logic [1:0] ROLE_A    = 2'd0;
    localparam logic [1:0] ROLE_B    = 2'd1;
    localparam logic [1:0] ROLE_BOTH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_A_PERCENT = 1'b1;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_END    = 2'd1,
        OP_DECIDE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [FIELD_TIME_W-1:0] time_now;
        logic                    run_class;
        logic                    has_a;
        logic                    has_b;
        logic                    has_local;
    } t_item;

endpackage

`default_nettype wire

### design/tsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/tsa_front.sv
// Front end: accepts items, classifies the request and queues it for the back end.
`default_nettype none

module tsa_front
    import tsa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    output logic                         o_busy,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [FIELD_TIME_W-1:0] i_time_now,
    input  wire logic                    i_run_class,
    input  wire logic                    i_has_class_a_work,
    input  wire logic                    i_has_class_b_work,
    input  wire logic                    i_has_local_work,
    output t_item                        o_item,
    output logic                         o_item_valid,
    input  wire logic                    i_pop
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    t_item      in_item;

    assign o_busy       = (r_cnt == 2'd2);
    assign push         = i_start && !o_busy;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        in_item.time_now  = i_time_now;
        in_item.run_class = i_run_class;
        in_item.has_a     = i_has_class_a_work;
        in_item.has_b     = i_has_class_b_work;
        in_item.has_local = i_has_local_work;
        unique case (i_req_type)
            REQ_START:  in_item.op = OP_START;
            REQ_END:    in_item.op = OP_END;
            REQ_DECIDE: in_item.op = OP_DECIDE;
            REQ_UNUSED: in_item.op = OP_NONE;
            default:    in_item.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

`default_nettype wire

### design/tsa_back.sv
// Back end: start queue, busy-time accounting, window eviction and decisions.
`default_nettype none

module tsa_back
    import tsa_pkg::*;
#(
    parameter int unsigned START_DEPTH  = 16,
    parameter int unsigned WINDOW_DEPTH = 64,
    parameter int unsigned TIME_BITS    = 48
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_item                   i_item,
    input  wire logic                    i_item_valid,
    output logic                         o_pop,
    input  wire logic [FIELD_TIME_W-1:0] i_window_length,
    input  wire logic [PCT_W-1:0]        i_class_a_percent,
    output logic                         o_done,
    output logic                         o_priority_res,
    output logic [1:0]                   o_role,
    output logic [1:0]                   o_status,
    output logic [FIELD_TIME_W-1:0]      o_class_a_total,
    output logic [FIELD_TIME_W-1:0]      o_class_b_total
);

    localparam int unsigned TW  = TIME_BITS;
    localparam int unsigned SW  = TW + 1;
    localparam int unsigned CW  = (SW > FIELD_TIME_W) ? SW : FIELD_TIME_W;
    localparam int unsigned PW  = SW + PCT_W;
    localparam int unsigned SAW = $clog2(START_DEPTH);
    localparam int unsigned SCW = $clog2(START_DEPTH + 1);
    localparam int unsigned WAW = $clog2(WINDOW_DEPTH);
    localparam int unsigned WCW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_START   = 12'b0000_0000_0010,
        ST_END_RD  = 12'b0000_0000_0100,
        ST_END_EL  = 12'b0000_0000_1000,
        ST_END_ADD = 12'b0000_0001_0000,
        ST_WR      = 12'b0000_0010_0000,
        ST_CHK     = 12'b0000_0100_0000,
        ST_EV      = 12'b0000_1000_0000,
        ST_DEC1    = 12'b0001_0000_0000,
        ST_DEC2    = 12'b0010_0000_0000,
        ST_DEC3    = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    t_item            r_item, n_item;
    logic [SAW-1:0]   r_sq_head, n_sq_head;
    logic [SCW-1:0]   r_sq_cnt, n_sq_cnt;
    logic [WAW-1:0]   r_wq_head, n_wq_head;
    logic [WCW-1:0]   r_wq_cnt, n_wq_cnt;
    logic [TW-1:0]    r_a, n_a, r_b, n_b;
    logic [TW-1:0]    r_el, n_el;
    logic             r_cls, n_cls;
    logic             r_last_pri, n_last_pri;
    logic [SW-1:0]    r_total, n_total;
    logic             r_forced, n_forced;
    logic [1:0]       r_role, n_role, r_status, n_status;
    logic [PCT_W-1:0] r_pct, n_pct;
    logic [PW-1:0]    r_pa, n_pa, r_pt, n_pt;

    logic                    r_o_done;
    logic                    r_o_pri;
    logic [1:0]              r_o_role, r_o_status;
    logic [FIELD_TIME_W-1:0] r_o_a, r_o_b;

    logic           sq_we, wq_we;
    logic [SAW-1:0] sq_tail;
    logic [WAW-1:0] wq_tail;
    logic [SAW:0]   sq_sum;
    logic [WAW:0]   wq_sum;
    logic [TW:0]    s_rdata, w_rdata;
    logic [TW:0]    sat_sum;
    logic [TW-1:0]  e_t, now_t;
    logic           e_cls, typ;

    assign sq_sum  = (SAW+1)'(r_sq_head) + (SAW+1)'(r_sq_cnt);
    assign sq_tail = (sq_sum >= (SAW+1)'(START_DEPTH)) ?
                     SAW'(sq_sum - (SAW+1)'(START_DEPTH)) : SAW'(sq_sum);
    assign wq_sum  = (WAW+1)'(r_wq_head) + (WAW+1)'(r_wq_cnt);
    assign wq_tail = (wq_sum >= (WAW+1)'(WINDOW_DEPTH)) ?
                     WAW'(wq_sum - (WAW+1)'(WINDOW_DEPTH)) : WAW'(wq_sum);

    assign sq_we = (r_state == ST_START) && (r_sq_cnt < SCW'(START_DEPTH));
    assign wq_we = (r_state == ST_WR);
    assign now_t = TW'(r_item.time_now);
    assign e_cls = w_rdata[TW];
    assign e_t   = w_rdata[TW-1:0];
    assign o_pop = (r_state == ST_IDLE) && i_item_valid;

    tsa_ram #(
        .WIDTH (TW + 1),
        .DEPTH (START_DEPTH)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (sq_tail),
        .i_wdata ({r_item.run_class, now_t}),
        .i_raddr (r_sq_head),
        .o_rdata (s_rdata)
    );

    tsa_ram #(
        .WIDTH (TW + 1),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (wq_we),
        .i_waddr (wq_tail),
        .i_wdata ({r_cls, r_el}),
        .i_raddr (r_wq_head),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_sq_head  = r_sq_head;
        n_sq_cnt   = r_sq_cnt;
        n_wq_head  = r_wq_head;
        n_wq_cnt   = r_wq_cnt;
        n_a        = r_a;
        n_b        = r_b;
        n_el       = r_el;
        n_cls      = r_cls;
        n_last_pri = r_last_pri;
        n_total    = r_total;
        n_forced   = r_forced;
        n_role     = r_role;
        n_status   = r_status;
        n_pct      = r_pct;
        n_pa       = r_pa;
        n_pt       = r_pt;
        sat_sum    = {1'b0, r_a} + {1'b0, r_el};
        typ        = 1'b0;
        if (r_cls) begin
            sat_sum = {1'b0, r_b} + {1'b0, r_el};
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_item   = i_item;
                    n_role   = ROLE_A;
                    n_status = STATUS_OK;
                    n_forced = 1'b0;
                    unique case (i_item.op)
                        OP_START:  n_state = ST_START;
                        OP_END:    n_state = ST_END_RD;
                        OP_DECIDE: n_state = ST_DEC1;
                        OP_NONE:   n_state = ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_START: begin
                if (sq_we) begin
                    n_sq_cnt = r_sq_cnt + SCW'(1);
                end else begin
                    n_status = STATUS_SQ_FULL;
                end
                n_state = ST_DONE;
            end
            ST_END_RD: begin
                if (r_sq_cnt == '0) begin
                    n_status = STATUS_NO_START;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_END_EL;
                end
            end
            ST_END_EL: begin
                n_el      = now_t - s_rdata[TW-1:0];
                n_cls     = s_rdata[TW];
                n_sq_cnt  = r_sq_cnt - SCW'(1);
                n_sq_head = (r_sq_head == SAW'(START_DEPTH - 1)) ? '0 : r_sq_head + SAW'(1);
                n_state   = ST_END_ADD;
            end
            ST_END_ADD: begin
                if (r_cls) begin
                    n_b = sat_sum[TW] ? '1 : sat_sum[TW-1:0];
                end else begin
                    n_a = sat_sum[TW] ? '1 : sat_sum[TW-1:0];
                end
                if (r_wq_cnt >= WCW'(WINDOW_DEPTH)) begin
                    n_forced = 1'b1;
                    n_status = STATUS_EVICT;
                    n_state  = ST_EV;
                end else begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                n_wq_cnt = r_wq_cnt + WCW'(1);
                n_total  = SW'(r_a) + SW'(r_b);
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                if (r_wq_cnt != '0 && CW'(r_total) > CW'(i_window_length)) begin
                    n_state = ST_EV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EV: begin
                if (!e_cls && r_a >= e_t) begin
                    n_a = r_a - e_t;
                end else if (r_b >= e_t) begin
                    n_b = r_b - e_t;
                end
                if (r_total > SW'(e_t)) begin
                    n_total = r_total - SW'(e_t);
                end
                n_wq_head = (r_wq_head == WAW'(WINDOW_DEPTH - 1)) ? '0 : r_wq_head + WAW'(1);
                n_wq_cnt  = r_wq_cnt - WCW'(1);
                n_forced  = 1'b0;
                n_state   = r_forced ? ST_WR : ST_CHK;
            end
            ST_DEC1: begin
                n_total = SW'(r_a) + SW'(r_b);
                n_pct   = (i_class_a_percent > PCT_FULL) ? PCT_FULL : i_class_a_percent;
                n_state = ST_DEC2;
            end
            ST_DEC2: begin
                n_pa    = PW'(r_a) * PW'(PCT_FULL);
                n_pt    = PW'(r_total) * PW'(r_pct);
                n_state = ST_DEC3;
            end
            ST_DEC3: begin
                typ = (r_pa > r_pt);
                if (!r_item.has_a && r_item.has_b && !typ) begin
                    typ = 1'b1;
                end else if (r_item.has_a && !r_item.has_b && typ) begin
                    typ = 1'b0;
                end
                n_last_pri = typ;
                n_role     = typ ? ROLE_B : ROLE_A;
                if (r_item.has_local && !r_item.has_a && !r_item.has_b) begin
                    n_role = ROLE_BOTH;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_el       <= n_el;
        r_cls      <= n_cls;
        r_total    <= n_total;
        r_role     <= n_role;
        r_status   <= n_status;
        r_pct      <= n_pct;
        r_pa       <= n_pa;
        r_pt       <= n_pt;
        r_o_pri    <= r_last_pri;
        r_o_role   <= r_role;
        r_o_status <= r_status;
        r_o_a      <= FIELD_TIME_W'(r_a);
        r_o_b      <= FIELD_TIME_W'(r_b);
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_sq_head  <= '0;
            r_sq_cnt   <= '0;
            r_wq_head  <= '0;
            r_wq_cnt   <= '0;
            r_a        <= '0;
            r_b        <= '0;
            r_last_pri <= 1'b1;
            r_forced   <= 1'b0;
            r_o_done   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sq_head  <= n_sq_head;
            r_sq_cnt   <= n_sq_cnt;
            r_wq_head  <= n_wq_head;
            r_wq_cnt   <= n_wq_cnt;
            r_a        <= n_a;
            r_b        <= n_b;
            r_last_pri <= n_last_pri;
            r_forced   <= n_forced;
            r_o_done   <= (r_state == ST_DONE);
        end
    end

    assign o_done          = r_o_done;
    assign o_priority_res  = r_o_pri;
    assign o_role          = r_o_role;
    assign o_status        = r_o_status;
    assign o_class_a_total = r_o_a;
    assign o_class_b_total = r_o_b;

endmodule

`default_nettype wire

### design/time_share_two_class_arbiter.sv
// Top level of the two-class time-share arbiter: configuration registers and front/back ends.
//
// Items enter on i_start while o_busy is low and land in a two-entry queue; o_busy is high
// only while that queue is full. The back end runs one item at a time and reports each
// result with a one-cycle o_done strobe that the receiver cannot stall. A start request is
// queued in ST_START, an unused one goes straight to ST_DONE, and a decide runs ST_DEC1 to
// ST_DEC3. An end with an empty start queue stops in ST_END_RD; any other end reads the
// start queue, adds the elapsed time, forces one eviction if the window queue is full,
// writes the entry, then evicts one window RAM entry at a time through its single read port.
// Queue RAMs need no clearing after reset. Configuration writes are always accepted
// (o_cfg_ready is tied high) and should only occur while idle.
`default_nettype none

module time_share_two_class_arbiter
    import tsa_pkg::*;
#(
    parameter int unsigned START_DEPTH  = 16,
    parameter int unsigned WINDOW_DEPTH = 64,
    parameter int unsigned TIME_BITS    = 48
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    output logic                         o_busy,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [FIELD_TIME_W-1:0] i_time_now,
    input  wire logic                    i_run_class,
    input  wire logic                    i_has_class_a_work,
    input  wire logic                    i_has_class_b_work,
    input  wire logic                    i_has_local_work,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [FIELD_TIME_W-1:0] i_cfg_data,
    output logic                         o_done,
    output logic                         o_priority_res,
    output logic [1:0]                   o_role,
    output logic [1:0]                   o_status,
    output logic [FIELD_TIME_W-1:0]      o_class_a_total,
    output logic [FIELD_TIME_W-1:0]      o_class_b_total
);

    logic [FIELD_TIME_W-1:0] r_window_length;
    logic [PCT_W-1:0]        r_class_a_percent;
    t_item                   item;
    logic                    item_valid;
    logic                    pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length   <= 48'd1000000;
            r_class_a_percent <= 7'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW_LENGTH:   r_window_length   <= i_cfg_data;
                REG_CLASS_A_PERCENT: r_class_a_percent <= i_cfg_data[PCT_W-1:0];
                default:             r_window_length   <= r_window_length;
            endcase
        end
    end

    tsa_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_req_type         (i_req_type),
        .i_time_now         (i_time_now),
        .i_run_class        (i_run_class),
        .i_has_class_a_work (i_has_class_a_work),
        .i_has_class_b_work (i_has_class_b_work),
        .i_has_local_work   (i_has_local_work),
        .o_item             (item),
        .o_item_valid       (item_valid),
        .i_pop              (pop)
    );

    tsa_back #(
        .START_DEPTH  (START_DEPTH),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TIME_BITS    (TIME_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (item),
        .i_item_valid      (item_valid),
        .o_pop             (pop),
        .i_window_length   (r_window_length),
        .i_class_a_percent (r_class_a_percent),
        .o_done            (o_done),
        .o_priority_res    (o_priority_res),
        .o_role            (o_role),
        .o_status          (o_status),
        .o_class_a_total   (o_class_a_total),
        .o_class_b_total   (o_class_b_total)
    );

endmodule

`default_nettype wire

### bench/arbiter_checker.sv
// Checker for the time-share arbiter: predicts every item's result and compares it with the block.
module arbiter_checker
    import tsa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_busy,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [FIELD_TIME_W-1:0] i_time_now,
    input  wire logic                    i_run_class,
    input  wire logic                    i_has_class_a_work,
    input  wire logic                    i_has_class_b_work,
    input  wire logic                    i_has_local_work,
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [FIELD_TIME_W-1:0] i_cfg_data,
    input  wire logic                    i_done,
    input  wire logic                    i_priority_res,
    input  wire logic [1:0]              i_role,
    input  wire logic [1:0]              i_status,
    input  wire logic [FIELD_TIME_W-1:0] i_class_a_total,
    input  wire logic [FIELD_TIME_W-1:0] i_class_b_total,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SQ_DEPTH  = 16;
    localparam int WIN_DEPTH = 64;
    localparam logic [63:0] TIME_MAX = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic                    prio;
        logic [1:0]              role;
        logic [1:0]              status;
        logic [FIELD_TIME_W-1:0] a_total;
        logic [FIELD_TIME_W-1:0] b_total;
    } t_outcome;

    t_outcome pending_outcomes[$];

    logic                    run_cls[SQ_DEPTH];
    logic [FIELD_TIME_W-1:0] run_t0[SQ_DEPTH];
    int                      run_head;
    int                      run_count;
    logic                    win_cls[WIN_DEPTH];
    logic [63:0]             win_dur[WIN_DEPTH];
    int                      win_head;
    int                      win_count;
    logic [63:0]             busy_a;
    logic [63:0]             busy_b;
    logic                    last_prio;
    logic [FIELD_TIME_W-1:0] window_len;
    logic [PCT_W-1:0]        a_percent;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [63:0] add_sat(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] s;
        s = x + y;
        return (s > TIME_MAX) ? TIME_MAX : s;
    endfunction

    task automatic evict_oldest_run(inout logic [63:0] sum);
        logic        c;
        logic [63:0] d;
        c = win_cls[win_head];
        d = win_dur[win_head];
        if (!c && busy_a >= d) begin
            busy_a = busy_a - d;
        end else if (busy_b >= d) begin
            busy_b = busy_b - d;
        end
        if (sum > d) begin
            sum = sum - d;
        end
        win_head = (win_head + 1) % WIN_DEPTH;
        win_count--;
    endtask

    task automatic close_run(input logic [FIELD_TIME_W-1:0] now, output logic [1:0] st);
        logic                    c;
        logic [FIELD_TIME_W-1:0] diff;
        logic [63:0]             el;
        logic [63:0]             sum;
        int                      slot;
        st = STATUS_OK;
        if (run_count == 0) begin
            st = STATUS_NO_START;
        end else begin
            c = run_cls[run_head];
            diff = now - run_t0[run_head];
            el = 64'(diff);
            run_head = (run_head + 1) % SQ_DEPTH;
            run_count--;
            if (!c) begin
                busy_a = add_sat(busy_a, el);
            end else begin
                busy_b = add_sat(busy_b, el);
            end
            if (win_count >= WIN_DEPTH) begin
                sum = busy_a + busy_b;
                evict_oldest_run(sum);
                st = STATUS_EVICT;
            end
            slot = (win_head + win_count) % WIN_DEPTH;
            win_cls[slot] = c;
            win_dur[slot] = el;
            win_count++;
            sum = busy_a + busy_b;
            while (win_count != 0 && sum > 64'(window_len)) begin
                evict_oldest_run(sum);
            end
        end
    endtask

    task automatic compute_outcome(input t_op op, input logic [FIELD_TIME_W-1:0] now,
                                   input logic cls, input logic ha, input logic hb,
                                   input logic hl);
        logic [1:0]  st;
        logic [1:0]  rl;
        logic [63:0] sum;
        logic [63:0] pct;
        logic        typ;
        int          slot;
        t_outcome    res;
        st = STATUS_OK;
        rl = ROLE_A;
        case (op)
            OP_START: begin
                if (run_count >= SQ_DEPTH) begin
                    st = STATUS_SQ_FULL;
                end else begin
                    slot = (run_head + run_count) % SQ_DEPTH;
                    run_cls[slot] = cls;
                    run_t0[slot] = now;
                    run_count++;
                end
            end
            OP_END: begin
                close_run(now, st);
            end
            OP_DECIDE: begin
                sum = busy_a + busy_b;
                pct = (a_percent > PCT_FULL) ? 64'(PCT_FULL) : 64'(a_percent);
                typ = (busy_a * 64'(PCT_FULL) > sum * pct);
                if (!ha && hb && !typ) begin
                    typ = 1'b1;
                end else if (ha && !hb && typ) begin
                    typ = 1'b0;
                end
                last_prio = typ;
                rl = typ ? ROLE_B : ROLE_A;
                if (hl && !ha && !hb) begin
                    rl = ROLE_BOTH;
                end
            end
            default: begin
            end
        endcase
        res.prio = last_prio;
        res.role = rl;
        res.status = st;
        res.a_total = busy_a[FIELD_TIME_W-1:0];
        res.b_total = busy_b[FIELD_TIME_W-1:0];
        pending_outcomes.push_back(res);
    endtask

    task automatic check_result;
        t_outcome want;
        if (pending_outcomes.size() == 0) begin
            report_mismatch("result with no item pending", 64'(i_status), 64'd0);
        end else begin
            want = pending_outcomes.pop_front();
            if (i_priority_res !== want.prio)
                report_mismatch("priority_res", 64'(i_priority_res), 64'(want.prio));
            if (i_role !== want.role)
                report_mismatch("role", 64'(i_role), 64'(want.role));
            if (i_status !== want.status)
                report_mismatch("status", 64'(i_status), 64'(want.status));
            if (i_class_a_total !== want.a_total)
                report_mismatch("class_a_total", 64'(i_class_a_total), 64'(want.a_total));
            if (i_class_b_total !== want.b_total)
                report_mismatch("class_b_total", 64'(i_class_b_total), 64'(want.b_total));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_outcomes.delete();
            run_head = 0;
            run_count = 0;
            win_head = 0;
            win_count = 0;
            busy_a = '0;
            busy_b = '0;
            last_prio = 1'b1;
            window_len = 48'd1000000;
            a_percent = 7'd50;
        end else begin
            if (i_done) begin
                check_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WINDOW_LENGTH:   window_len = i_cfg_data;
                    REG_CLASS_A_PERCENT: a_percent = i_cfg_data[PCT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                compute_outcome(t_op'(i_req_type), i_time_now, i_run_class,
                                i_has_class_a_work, i_has_class_b_work, i_has_local_work);
            end
        end
        o_pending = pending_outcomes.size();
    end

endmodule

### bench/time_share_two_class_arbiter_tb.sv
// Testbench top for the time-share arbiter: clock, reset, stimulus phases and verdict.
module time_share_two_class_arbiter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsa_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASE_ITEMS = 185;
    localparam int NUM_PHASES  = 8;
    localparam int SQ_DEPTH    = 16;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    t_op                     req_op;
    logic [FIELD_TIME_W-1:0] time_now;
    logic                    run_class;
    logic                    has_a;
    logic                    has_b;
    logic                    has_local;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [FIELD_TIME_W-1:0] cfg_data;
    logic                    done;
    logic                    priority_res;
    logic [1:0]              role;
    logic [1:0]              status;
    logic [FIELD_TIME_W-1:0] a_total;
    logic [FIELD_TIME_W-1:0] b_total;
    int                      fail_count;
    int                      pending;

    int                      stall_cycles;
    logic [FIELD_TIME_W-1:0] clock_us;
    int                      open_runs;
    int                      burst_starts;
    int                      burst_ends;
    bit                      idle_allowed;
    bit                      idle_on;
    int                      stretch_left;

    time_share_two_class_arbiter uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_start            (start),
        .o_busy             (busy),
        .i_req_type         (req_op),
        .i_time_now         (time_now),
        .i_run_class        (run_class),
        .i_has_class_a_work (has_a),
        .i_has_class_b_work (has_b),
        .i_has_local_work   (has_local),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_done             (done),
        .o_priority_res     (priority_res),
        .o_role             (role),
        .o_status           (status),
        .o_class_a_total    (a_total),
        .o_class_b_total    (b_total)
    );

    arbiter_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_req_type         (req_op),
        .i_time_now         (time_now),
        .i_run_class        (run_class),
        .i_has_class_a_work (has_a),
        .i_has_class_b_work (has_b),
        .i_has_local_work   (has_local),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_done             (done),
        .i_priority_res     (priority_res),
        .i_role             (role),
        .i_status           (status),
        .i_class_a_total    (a_total),
        .i_class_b_total    (b_total),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input t_op op, input logic [FIELD_TIME_W-1:0] t,
                             input logic cls, input logic ha, input logic hb,
                             input logic hl);
        @(negedge clk);
        start = 1'b1;
        req_op = op;
        time_now = t;
        run_class = cls;
        has_a = ha;
        has_b = hb;
        has_local = hl;
        do @(posedge clk); while (busy);
        if (op == OP_START && open_runs < SQ_DEPTH) begin
            open_runs++;
        end else if (op == OP_END && open_runs > 0) begin
            open_runs--;
        end
    endtask

    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // hold off until every item has its result
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [FIELD_TIME_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [FIELD_TIME_W-1:0] wl, input logic [PCT_W-1:0] pct);
        logic [FIELD_TIME_W-1:0] d;
        drain();
        write_reg(REG_WINDOW_LENGTH, wl);
        d = FIELD_TIME_W'({$urandom, $urandom});
        d[PCT_W-1:0] = pct;
        write_reg(REG_CLASS_A_PERCENT, d);
    endtask

    task automatic random_item(input int unsigned max_step);
        t_op                     op;
        logic [FIELD_TIME_W-1:0] t;
        int                      r;
        if (burst_starts > 0) begin
            op = OP_START;
            burst_starts--;
        end else if (burst_ends > 0) begin
            op = OP_END;
            burst_ends--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op = OP_NONE;
            end else if (r < 23) begin
                op = OP_DECIDE;
            end else if (r < 25) begin
                // fill the start queue and push past it
                op = OP_START;
                burst_starts = SQ_DEPTH - open_runs + $urandom_range(0, 2);
            end else if (r < 27) begin
                op = OP_END;
                burst_ends = open_runs + $urandom_range(0, 1);
            end else begin
                op = $urandom_range(0, 1) ? OP_START : OP_END;
            end
        end
        if (op == OP_START || op == OP_END) begin
            if ($urandom_range(0, 49) == 0) begin
                clock_us = FIELD_TIME_W'({$urandom, $urandom});
            end else begin
                clock_us = clock_us + FIELD_TIME_W'($urandom_range(0, max_step));
            end
            t = clock_us;
        end else begin
            t = FIELD_TIME_W'({$urandom, $urandom});
        end
        send_item(op, t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (idle_allowed) begin
            stretch_left--;
            if (stretch_left <= 0) begin
                idle_on = !idle_on;
                stretch_left = $urandom_range(10, 60);
            end
            if (idle_on && $urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 7));
            end
        end
    endtask

    initial begin
        logic [FIELD_TIME_W-1:0] wl;
        logic [PCT_W-1:0]        pct;
        int unsigned             step;
        rst_n = 1'b0;
        start = 1'b0;
        req_op = OP_START;
        time_now = '0;
        run_class = 1'b0;
        has_a = 1'b0;
        has_b = 1'b0;
        has_local = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_LENGTH;
        cfg_data = '0;
        stall_cycles = 0;
        clock_us = '0;
        open_runs = 0;
        burst_starts = 0;
        burst_ends = 0;
        idle_allowed = 1'b0;
        idle_on = 1'b0;
        stretch_left = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        configure(48'd1000000, 7'd50);
        send_item(OP_DECIDE, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_NONE, '1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(OP_END, 48'd50, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_START, 48'd100, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_START, 48'd150, 1'b1, 1'b0, 1'b0, 1'b0);
        send_item(OP_END, 48'd400, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_END, 48'd450, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_DECIDE, '0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_item(OP_DECIDE, '0, 1'b0, 1'b0, 1'b1, 1'b0);
        send_item(OP_DECIDE, '0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_item(OP_DECIDE, '0, 1'b0, 1'b0, 1'b0, 1'b1);
        // timestamps going backwards
        send_item(OP_START, '1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_END, 48'd5, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_START, 48'd10, 1'b1, 1'b0, 1'b0, 1'b0);
        send_item(OP_END, 48'd3, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_DECIDE, '0, 1'b0, 1'b1, 1'b1, 1'b0);
        // saturating totals, percent above full scale
        configure('1, 7'd127);
        send_item(OP_START, 48'd1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_END, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_START, 48'd20, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_END, 48'd19, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_START, 48'd7, 1'b1, 1'b0, 1'b0, 1'b0);
        send_item(OP_END, 48'd6, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(OP_DECIDE, '0, 1'b0, 1'b1, 1'b1, 1'b0);
        send_item(OP_DECIDE, '0, 1'b0, 1'b0, 1'b0, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin wl = 48'd1000000; pct = 7'd50; step = 2000; end
                1: begin wl = '0; pct = 7'd0; step = 50; end
                2: begin wl = '1; pct = 7'd100; step = 500; end
                3: begin wl = 48'($urandom_range(100, 5000)); pct = 7'd127; step = 300; end
                4: begin
                    wl = FIELD_TIME_W'({$urandom, $urandom});
                    pct = 7'($urandom_range(0, 127));
                    step = $urandom_range(1, 1000000);
                end
                5: begin
                    wl = 48'($urandom_range(0, 300));
                    pct = 7'($urandom_range(0, 127));
                    step = 100;
                end
                6: begin wl = 48'd1000000; pct = 7'd1; step = 5000; end
                default: begin
                    wl = 48'($urandom_range(1000, 100000));
                    pct = 7'($urandom_range(0, 100));
                    step = 1000;
                end
            endcase
            configure(wl, pct);
            idle_allowed = (p != NUM_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item(step);
                if (p == 3 && i == PHASE_ITEMS / 2) begin
                    drain();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
